### rtl/bsfr_pkg.sv
// shared types, constants and the crc-8 byte fold for the frame receiver
// no dependencies; imported by every module of the block
package bsfr_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LIMIT_W = 11;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int IDX_W = 10;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] FLAG_START = 8'h7F;
    localparam logic [7:0] FLAG_STOP  = 8'h7E;
    localparam logic [7:0] FLAG_ESC   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;

    localparam logic [7:0]         POLY_RESET  = 8'h07;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    localparam logic [1:0] REG_CRC_POLY    = 2'd0;
    localparam logic [1:0] REG_FRAME_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        CODE_START = 2'd0,
        CODE_STOP  = 2'd1,
        CODE_ESC   = 2'd2,
        CODE_DATA  = 2'd3
    } item_code_t;

    typedef struct packed {
        item_code_t code;
        logic [7:0] rx_byte;
    } item_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] payload_length;
    } result_t;

    typedef struct packed {
        logic [7:0]         crc_polynomial;
        logic [LIMIT_W-1:0] frame_limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } rx_state_t;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/bsfr_front.sv
// front stage: takes received bytes and tags them as start, stop, escape or data
// depends on bsfr_pkg
module bsfr_front
    import bsfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output item_t      out_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    item_t classified;

    always_comb begin
        classified.rx_byte = in_byte;
        case (in_byte)
            FLAG_START: classified.code = CODE_START;
            FLAG_STOP:  classified.code = CODE_STOP;
            FLAG_ESC:   classified.code = CODE_ESC;
            default:    classified.code = CODE_DATA;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                item_next = classified;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### rtl/bsfr_queue.sv
// short queue of tagged bytes between the front and back stages
// depends on bsfr_pkg
module bsfr_queue
    import bsfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output item_t   out_item,
    output q_stat_t stat
);

    item_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_LVL_W-1:0]  level_reg, level_next;
    logic                push, pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = (level_reg == Q_LVL_W'(Q_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign push       = in_valid && !stat.full;
    assign pop        = out_ready && !stat.empty;
    assign out_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/bsfr_back.sv
// back stage: frame state, unescaping, crc-8 and byte count, with the result register
// depends on bsfr_pkg
module bsfr_back
    import bsfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    rx_state_t        state_reg, state_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       crc_reg, crc_next;
    logic             valid_reg, valid_next;
    result_t          result_reg, result_next;

    logic             take;
    logic [7:0]       data_byte;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] limit_ext;
    logic [CMP_W-1:0] eff_limit;
    logic [CMP_W-1:0] length_ext;
    logic             at_limit;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign data_byte  = esc_reg ? (in_item.rx_byte ^ ESC_XOR) : in_item.rx_byte;
    assign count_ext  = CMP_W'(count_reg);
    assign limit_ext  = CMP_W'(cfg.frame_limit);
    assign eff_limit  = (limit_ext > CMP_W'(MAX_FRAME_BYTES)) ? CMP_W'(MAX_FRAME_BYTES)
                                                               : limit_ext;
    assign at_limit   = (count_ext >= eff_limit);
    assign length_ext = count_ext - 1'b1;

    always_comb begin
        state_next = state_reg;
        if (take) begin
            case (state_reg)
                ST_HUNT: begin
                    if (in_item.code == CODE_START) state_next = ST_FRAME;
                end
                ST_FRAME: begin
                    if (in_item.code == CODE_STOP) begin
                        state_next = ST_HUNT;
                    end else if (in_item.code == CODE_DATA && at_limit) begin
                        state_next = ST_HUNT;
                    end
                end
                default: state_next = ST_HUNT;
            endcase
        end
    end

    always_comb begin
        esc_next    = esc_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        valid_next  = valid_reg && !out_ready;
        result_next = result_reg;
        if (take) begin
            case (state_reg)
                ST_HUNT: begin
                    if (in_item.code == CODE_START) begin
                        esc_next   = 1'b0;
                        count_next = '0;
                        crc_next   = '0;
                    end
                end
                ST_FRAME: begin
                    case (in_item.code)
                        CODE_STOP: begin
                            esc_next    = 1'b0;
                            valid_next  = 1'b1;
                            result_next = '0;
                            if (count_reg != '0 && crc_reg == '0) begin
                                result_next.kind           = KIND_GOOD;
                                result_next.payload_length = length_ext[IDX_W-1:0];
                            end else begin
                                result_next.kind = KIND_BAD;
                            end
                        end
                        CODE_START: begin
                            esc_next   = 1'b0;
                            count_next = '0;
                            crc_next   = '0;
                        end
                        CODE_ESC: begin
                            esc_next = 1'b1;
                        end
                        default: begin
                            esc_next    = 1'b0;
                            valid_next  = 1'b1;
                            result_next = '0;
                            if (at_limit) begin
                                result_next.kind = KIND_OVERFLOW;
                            end else begin
                                result_next.kind       = KIND_DATA;
                                result_next.data_byte  = data_byte;
                                result_next.byte_index = count_ext[IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                                crc_next   = crc8_fold(crc_reg, data_byte,
                                                       cfg.crc_polynomial);
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            esc_reg   <= 1'b0;
            count_reg <= '0;
            crc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/byte_stuffed_frame_receiver_crc8_core.sv
// top level of the byte-stuffed frame receiver with crc-8 check
// depends on bsfr_pkg, bsfr_front, bsfr_queue, bsfr_back
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata: rx_byte
//   m_       out  m_tvalid/m_tready    m_tuser: kind; m_tdata: data_byte, index, length
//   cfg_     in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// one byte per cycle sustained while m_ accepts; a taken byte passes the front register
// and the queue, its report then sits in the back result register; crc fold is combinational
// sync reset clears control state; registers go to polynomial 7 and limit 1024
// either side may stall on its own; the queue and result register absorb the slack
// config writes are always accepted and meant for idle periods only
module byte_stuffed_frame_receiver_crc8_core
    import bsfr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [7:0] data_byte, [17:8] byte_index, [27:18] payload_length
    output logic [1:0]   m_tuser,   // [1:0] kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    fr_valid, fr_ready;
    item_t   fr_item;
    logic    q_valid, q_ready;
    item_t   q_item;
    q_stat_t q_stat;
    result_t result;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CRC_POLY:    cfg_next.crc_polynomial = cfg_data[7:0];
                REG_FRAME_LIMIT: cfg_next.frame_limit    = cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_polynomial <= POLY_RESET;
            cfg_reg.frame_limit    <= LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bsfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    bsfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item),
        .stat      (q_stat)
    );

    bsfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {4'b0000, result.payload_length, result.byte_index, result.data_byte};

    a_reset_no_output: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_beat_reaches_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> fr_valid)
        else $error("accepted beat missing from front register");

    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_item)))
        else $error("front item changed while queue was full");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_good_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_GOOD) |-> (m_tdata[17:0] == 18'd0))
        else $error("good frame result carries byte fields");

endmodule

### test/testbench.sv
// self-checking bench for byte_stuffed_frame_receiver_crc8_core
// keeps its own deframer and crc-8 state, predicts every report beat and checks it in order
// needs bsfr_pkg and the rtl of the core
`timescale 1ns / 100ps

module testbench;
    import bsfr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MIX_BYTES = 65;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [10:0]  cfg_data;

    // bench copy of registers and receive state
    logic [7:0]   cfg_poly;
    logic [10:0]  cfg_limit;
    logic         rx_open;
    logic         rx_escape;
    logic [10:0]  rx_stored;
    logic [7:0]   rx_residue;

    result_t      reports_due[$];

    int tx_gap_pct;
    int rx_stall_pct;
    int bytes_sent = 0;
    int beats_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int kinds_seen[4] = '{0, 0, 0, 0};

    byte_stuffed_frame_receiver_crc8_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b,
                                            input logic [7:0] gen);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (fb ? gen : 8'h00);
        end
        return r;
    endfunction

    function automatic void open_frame();
        rx_open = 1'b1;
        rx_escape = 1'b0;
        rx_stored = '0;
        rx_residue = '0;
    endfunction

    // advance the receive state by one accepted byte, queue the report it causes
    function automatic void track_rx_byte(input logic [7:0] b);
        result_t    rep;
        logic [7:0] d;
        logic [10:0] cap;
        rep = '0;
        d = b;
        cap = (cfg_limit > 11'(MAX_FRAME_BYTES)) ? 11'(MAX_FRAME_BYTES) : cfg_limit;
        if (!rx_open) begin
            if (b == FLAG_START) open_frame();
        end else if (b == FLAG_STOP) begin
            rx_open = 1'b0;
            rx_escape = 1'b0;
            if (rx_stored != 0 && rx_residue == 0) begin
                rep.kind = KIND_GOOD;
                rep.payload_length = IDX_W'(rx_stored - 11'd1);
            end else begin
                rep.kind = KIND_BAD;
            end
            reports_due.push_back(rep);
        end else if (b == FLAG_START) begin
            open_frame();
        end else if (b == FLAG_ESC) begin
            rx_escape = 1'b1;
        end else begin
            if (rx_escape) begin
                d = b ^ ESC_XOR;
                rx_escape = 1'b0;
            end
            if (rx_stored >= cap) begin
                rx_open = 1'b0;
                rep.kind = KIND_OVERFLOW;
            end else begin
                rep.kind = KIND_DATA;
                rep.data_byte = d;
                rep.byte_index = IDX_W'(rx_stored);
                rx_stored = rx_stored + 11'd1;
                rx_residue = crc_next(rx_residue, d, cfg_poly);
            end
            reports_due.push_back(rep);
        end
    endfunction

    always @(negedge aclk) begin
        m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.data_byte = m_tdata[7:0];
            got.byte_index = m_tdata[17:8];
            got.payload_length = m_tdata[27:18];
            beats_checked++;
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind %0d data %02h index %0d length %0d",
                             got.kind, got.data_byte, got.byte_index, got.payload_length);
            end else begin
                want = reports_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected kind %0d data %02h index %0d length %0d",
                                 $time, want.kind, want.data_byte, want.byte_index,
                                 want.payload_length);
                        $display("                 got kind %0d data %02h index %0d length %0d",
                                 got.kind, got.data_byte, got.byte_index, got.payload_length);
                    end
                end else begin
                    kinds_seen[want.kind]++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d reports outstanding",
                     STALL_LIMIT, reports_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        track_rx_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // escape flags always, other bytes now and then (never those that unescape to a flag)
    task automatic send_stuffed(input logic [7:0] b, input int esc_pct);
        if (b == FLAG_START || b == FLAG_STOP || b == FLAG_ESC ||
            (b[7:2] != 6'b010111 && $urandom_range(99) < esc_pct)) begin
            send_byte(FLAG_ESC);
            send_byte(b ^ ESC_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    task automatic send_frame(input int n, input bit spoil, input int esc_pct);
        logic [7:0] acc;
        logic [7:0] b;
        acc = '0;
        send_byte(FLAG_START);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            acc = crc_next(acc, b, cfg_poly);
            send_stuffed(b, esc_pct);
        end
        if (spoil)
            acc = acc ^ 8'($urandom_range(255, 1));
        send_stuffed(acc, esc_pct);
        send_byte(FLAG_STOP);
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            case ($urandom_range(7))
                0: b = FLAG_START;
                1: b = FLAG_STOP;
                2: b = FLAG_ESC;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic configure(input logic [7:0] poly, input logic [10:0] limit);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_CRC_POLY;
        cfg_data <= {3'b000, poly};
        do @(posedge aclk); while (!cfg_ready);
        cfg_poly = poly;
        @(negedge aclk);
        cfg_index <= REG_FRAME_LIMIT;
        cfg_data <= limit;
        do @(posedge aclk); while (!cfg_ready);
        cfg_limit = limit;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // reset registers: hunting, empty frame, minimal good frame, escapes, restarts
    task automatic test_hunt_and_flags();
        send_byte(8'h00); send_byte(8'hFF); send_byte(FLAG_STOP); send_byte(FLAG_ESC);
        send_byte(8'h5F);
        send_byte(FLAG_START); send_byte(FLAG_STOP);
        send_byte(FLAG_START); send_byte(8'h00); send_byte(8'h00); send_byte(FLAG_STOP);
        send_byte(FLAG_START); send_byte(FLAG_ESC); send_byte(8'h5E);
        send_byte(FLAG_ESC); send_byte(FLAG_ESC); send_byte(8'h5D);
        send_byte(FLAG_ESC); send_byte(FLAG_STOP);
        send_byte(FLAG_START); send_byte(8'h41); send_byte(FLAG_ESC); send_byte(FLAG_START);
        send_byte(8'h80); send_byte(8'hFF); send_byte(FLAG_STOP);
    endtask

    task automatic test_register_extremes();
        configure(8'hFF, 11'd1);
        send_byte(FLAG_START); send_byte(8'hAA); send_byte(8'hBB); send_byte(FLAG_STOP);
        send_frame(0, 1'b0, 0);
        configure(8'h00, 11'd0);
        send_byte(FLAG_START); send_byte(8'h12);
        send_byte(FLAG_START); send_byte(FLAG_STOP);
    endtask

    // full 1 KiB of stored bytes, then overflow at the built-in cap under a wider limit
    task automatic test_long_frames();
        configure(8'hD5, 11'd2047);
        send_frame(1024, 1'b0, 0);
    endtask

    task automatic run_mix(input int tx_pct, input int rx_pct, input logic [7:0] poly,
                           input logic [10:0] limit);
        int first;
        int pick;
        configure(poly, limit);
        tx_gap_pct = tx_pct;
        rx_stall_pct = rx_pct;
        first = bytes_sent;
        while (bytes_sent - first < MIX_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                if ($urandom_range(4) == 0) send_noise($urandom_range(3, 1));
                send_frame(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12),
                           $urandom_range(99) < 15, 10);
            end else if (pick < 70) begin
                send_byte(FLAG_START);
                if ($urandom_range(1)) send_byte(FLAG_ESC);
                send_byte(FLAG_STOP);
            end else if (pick < 80) begin
                send_byte(FLAG_START);
                send_noise($urandom_range(6, 1));
                send_frame($urandom_range(10), 1'b0, 10);
            end else if (pick < 90) begin
                send_noise($urandom_range(8, 1));
            end else begin
                send_byte(FLAG_START);
                send_noise($urandom_range(3));
                send_byte(FLAG_ESC);
                if ($urandom_range(1)) send_byte(FLAG_STOP);
                send_frame($urandom_range(10), $urandom_range(1), 10);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_mix(0, 0, 8'h31, 11'd1024);
        run_mix(59, 0, 8'hFF, 11'd8);
        run_mix(0, 59, 8'h00, 11'd3);
        run_mix(25, 25, 8'h9B, 11'd40);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_CRC_POLY;
        cfg_data = '0;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        cfg_poly = POLY_RESET;
        cfg_limit = LIMIT_RESET;
        rx_open = 1'b0;
        rx_escape = 1'b0;
        rx_stored = '0;
        rx_residue = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_hunt_and_flags();
        test_register_extremes();
        test_long_frames();
        test_random_traffic();
        settle();

        $display("%0d bytes sent: directed flags, register extremes, a frame past the cap, four idle mixes",
                 bytes_sent);
        $display("%0d beats checked: %0d data, %0d good, %0d bad, %0d overflow, %0d mismatches",
                 beats_checked, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3],
                 mismatches);
        if (mismatches == 0 && reports_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
